>>> sv/buddy_page_allocator_assert.svh
// assertion macros for the buddy page allocator checker
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define BPA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpa assertion failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpa assertion failed");

`endif

>>> sv/bpa_pkg.sv
package bpa_pkg;

  localparam int PAGE_W     = 10;
  localparam int ORD_W      = 4;
  localparam int STAT_W     = 2;
  localparam int ADDR_W     = 32;
  localparam int PG_BYTE_LOG2 = 12;
  // wide enough for an index plus a block size of up to 2^15 pages
  localparam int CHK_W      = 17;

  localparam logic [ORD_W-1:0] NOT_HEAD = 4'hF;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTALLOC = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD      = 2'd3;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_INIT   = 15'h0002,
    S_ASCAN  = 15'h0004,
    S_AUNL   = 15'h0008,
    S_AUNL2  = 15'h0010,
    S_ASPL   = 15'h0020,
    S_ASPL2  = 15'h0040,
    S_FCHK   = 15'h0080,
    S_FCHK2  = 15'h0100,
    S_FMRG   = 15'h0200,
    S_FMRG2  = 15'h0400,
    S_FMRG3  = 15'h0800,
    S_FMRG4  = 15'h1000,
    S_FPUSH  = 15'h2000,
    S_FPUSH2 = 15'h4000
  } state_t;

endpackage

>>> sv/bpa_ram.sv
module bpa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/buddy_page_allocator.sv
// channel  | handshake            | payload
// in_      | in_valid / in_stall  | in_mode, in_block_order, in_page_index
// out_     | out_valid / out_stall| out_status, out_result_page, out_result_address
// cfg_     | cfg_valid / cfg_ready| cfg_pool_base_address
//
// one transaction at a time through a small sequencer; the cases:
// allocate: climbs orders above the asked one to a free block, then splits it down
// no free block: scans up past the top order; bad order: result at the accepting edge
// free: a bad index or a block not allocated ends early, else merges and pushes
// after reset a clearing pass over the NUM_PAGES pages loads the free lists; no input then
// in_stall stays high while a transaction is at work or its result is still held
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES    = 1024,
  parameter int ORDER_LEVELS = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [ORD_W-1:0]  in_block_order,
  input  logic [PAGE_W-1:0] in_page_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [PAGE_W-1:0] out_result_page,
  output logic [ADDR_W-1:0] out_result_address,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_pool_base_address
);

  localparam int PW       = $clog2(NUM_PAGES);
  localparam int OW       = $clog2(ORDER_LEVELS);
  localparam int OXW      = OW + 1;
  localparam int TOP      = ORDER_LEVELS - 1;
  localparam int TOPSZ    = 1 << TOP;
  localparam int FULL     = (NUM_PAGES / TOPSZ) * TOPSZ;
  localparam int LAST_TOP = (FULL >= TOPSZ) ? FULL - TOPSZ : 0;

  localparam logic [PW:0]      NPX   = (PW+1)'(NUM_PAGES);
  localparam logic [PW:0]      FULLX = (PW+1)'(FULL);
  localparam logic [CHK_W-1:0] NPCHK = CHK_W'(NUM_PAGES);
  localparam logic [OXW-1:0]   TOPX  = OXW'(TOP);
  localparam logic [ORD_W-1:0] TOP4  = ORD_W'(TOP);

  state_t state_r, state_nxt;

  logic [OXW-1:0]    o_r, o_nxt;
  logic [OXW-1:0]    req_r, req_nxt;
  logic [PAGE_W-1:0] pidx_r, pidx_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [PW-1:0]     b_r, b_nxt;
  logic [PW-1:0]     idx_r, idx_nxt;
  logic [ADDR_W-1:0] base_r;

  logic [PW-1:0] first_r [ORDER_LEVELS];
  logic [PW-1:0] first_nxt [ORDER_LEVELS];
  logic [PW-1:0] last_r [ORDER_LEVELS];
  logic [PW-1:0] last_nxt [ORDER_LEVELS];
  logic          ne_r [ORDER_LEVELS];
  logic          ne_nxt [ORDER_LEVELS];

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  // page RAM ports
  logic [PW-1:0]    raddr;
  logic             busy_we, ord_we, nxt_we, prv_we;
  logic [PW-1:0]    busy_wa, ord_wa, nxt_wa, prv_wa;
  logic             busy_wd;
  logic [ORD_W-1:0] ord_wd;
  logic [PW-1:0]    nxt_wd, prv_wd;
  logic             busy_rd;
  logic [ORD_W-1:0] ord_rd;
  logic [PW-1:0]    nxt_rd, prv_rd;

  bpa_ram #(.W(1), .D(NUM_PAGES)) u_busy (
    .clk(clk), .we(busy_we), .waddr(busy_wa), .wdata(busy_wd), .raddr(raddr), .rdata(busy_rd)
  );
  bpa_ram #(.W(ORD_W), .D(NUM_PAGES)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(raddr), .rdata(ord_rd)
  );
  bpa_ram #(.W(PW), .D(NUM_PAGES)) u_nxt (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(raddr), .rdata(nxt_rd)
  );
  bpa_ram #(.W(PW), .D(NUM_PAGES)) u_prv (
    .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(raddr), .rdata(prv_rd)
  );

  logic [OW-1:0]      oi, mi;
  logic [OXW-1:0]     om1, op1;
  logic [PW:0]        ix;
  logic [PW-1:0]      bsel, lo, hi;
  logic [CHK_W-1:0]   pchk, csize;
  logic               fin;
  logic [STAT_W-1:0]  fin_status;
  logic               is_f, is_l;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign cfg_ready = 1'b1;

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_result_page    = page_r;
  assign out_result_address = addr_r;

  assign oi    = o_r[OW-1:0];
  assign om1   = o_r - OXW'(1);
  assign op1   = o_r + OXW'(1);
  assign mi    = om1[OW-1:0];
  assign ix    = {1'b0, idx_r};
  assign bsel  = p_r ^ (PW'(1) << o_r);
  assign lo    = (p_r < b_r) ? p_r : b_r;
  assign hi    = (p_r < b_r) ? b_r : p_r;
  assign pchk  = CHK_W'(pidx_r);
  assign csize = CHK_W'(1) << req_r;
  assign is_f  = first_r[oi] == b_r;
  assign is_l  = last_r[oi] == b_r;

  always_comb begin
    state_nxt  = state_r;
    o_nxt      = o_r;
    req_nxt    = req_r;
    pidx_nxt   = pidx_r;
    p_nxt      = p_r;
    b_nxt      = b_r;
    idx_nxt    = idx_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    ne_nxt     = ne_r;
    raddr      = p_r;
    busy_we    = 1'b0;
    busy_wa    = p_r;
    busy_wd    = 1'b0;
    ord_we     = 1'b0;
    ord_wa     = p_r;
    ord_wd     = '0;
    nxt_we     = 1'b0;
    nxt_wa     = p_r;
    nxt_wd     = '0;
    prv_we     = 1'b0;
    prv_wa     = p_r;
    prv_wd     = '0;
    fin        = 1'b0;
    fin_status = ST_OK;

    unique case (state_r)
      S_INIT: begin
        busy_we = 1'b1;
        ord_we  = 1'b1;
        nxt_we  = 1'b1;
        prv_we  = 1'b1;
        busy_wa = idx_r;
        ord_wa  = idx_r;
        nxt_wa  = idx_r;
        prv_wa  = idx_r;
        if (ix < FULLX) begin
          if ((idx_r & PW'(TOPSZ - 1)) == '0) begin
            ord_wd = TOP4;
            prv_wd = (idx_r == '0) ? '0 : idx_r - PW'(TOPSZ);
            nxt_wd = (idx_r != PW'(LAST_TOP)) ? idx_r + PW'(TOPSZ) : '0;
          end else begin
            ord_wd = NOT_HEAD;
          end
        end else begin
          // pages past the last whole top block sit in list 0
          ord_wd = '0;
          prv_wd = (ix > FULLX) ? idx_r - PW'(1) : '0;
          nxt_wd = (ix < NPX - (PW+1)'(1)) ? idx_r + PW'(1) : '0;
        end
        if (idx_r == PW'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + PW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          req_nxt  = OXW'(in_block_order);
          pidx_nxt = in_page_index;
          if (in_block_order > TOP4) begin
            fin        = 1'b1;
            fin_status = ST_BAD;
          end else if (in_mode == MODE_ALLOC) begin
            o_nxt     = OXW'(in_block_order);
            state_nxt = S_ASCAN;
          end else begin
            state_nxt = S_FCHK;
          end
        end
      end
      S_ASCAN: begin
        if (o_r > TOPX) begin
          fin        = 1'b1;
          fin_status = ST_NOFREE;
        end else if (ne_r[oi]) begin
          p_nxt     = first_r[oi];
          state_nxt = S_AUNL;
        end else begin
          o_nxt = op1;
        end
      end
      S_AUNL: begin
        prv_we    = 1'b1;
        state_nxt = S_AUNL2;
      end
      S_AUNL2: begin
        if (first_r[oi] == last_r[oi]) begin
          ne_nxt[oi]    = 1'b0;
          first_nxt[oi] = '0;
          last_nxt[oi]  = '0;
        end else begin
          first_nxt[oi] = nxt_rd;
        end
        nxt_we    = 1'b1;
        state_nxt = S_ASPL;
      end
      S_ASPL: begin
        if (o_r == req_r) begin
          busy_we    = 1'b1;
          busy_wd    = 1'b1;
          ord_we     = 1'b1;
          ord_wd     = ORD_W'(req_r);
          fin        = 1'b1;
          fin_status = ST_OK;
        end else begin
          // lower half to the tail of the next order down
          ord_we = 1'b1;
          ord_wd = ORD_W'(om1);
          prv_we = 1'b1;
          if (ne_r[mi]) begin
            nxt_we = 1'b1;
            nxt_wa = last_r[mi];
            nxt_wd = p_r;
            prv_wd = last_r[mi];
          end else begin
            first_nxt[mi] = p_r;
            ne_nxt[mi]    = 1'b1;
          end
          last_nxt[mi] = p_r;
          o_nxt        = om1;
          state_nxt    = S_ASPL2;
        end
      end
      S_ASPL2: begin
        nxt_we    = 1'b1;
        p_nxt     = p_r + (PW'(1) << o_r);
        state_nxt = S_ASPL;
      end
      S_FCHK: begin
        if (pchk >= NPCHK || (pchk & (csize - CHK_W'(1))) != '0 || pchk + csize > NPCHK) begin
          fin        = 1'b1;
          fin_status = ST_BAD;
        end else begin
          p_nxt     = PW'(pidx_r);
          raddr     = PW'(pidx_r);
          o_nxt     = req_r;
          state_nxt = S_FCHK2;
        end
      end
      S_FCHK2: begin
        if (!busy_rd || ord_rd != ORD_W'(req_r)) begin
          fin        = 1'b1;
          fin_status = ST_NOTALLOC;
        end else begin
          busy_we   = 1'b1;
          state_nxt = S_FMRG;
        end
      end
      S_FMRG: begin
        if (o_r >= TOPX) begin
          state_nxt = S_FPUSH;
        end else if (32'(o_r) >= PW || {1'b0, bsel} >= NPX) begin
          state_nxt = S_FPUSH;
        end else begin
          raddr     = bsel;
          b_nxt     = bsel;
          state_nxt = S_FMRG2;
        end
      end
      S_FMRG2: begin
        if (busy_rd || ord_rd != ORD_W'(o_r)) begin
          state_nxt = S_FPUSH;
        end else begin
          priority if (is_f && is_l) begin
            ne_nxt[oi]    = 1'b0;
            first_nxt[oi] = '0;
            last_nxt[oi]  = '0;
          end else if (is_f) begin
            first_nxt[oi] = nxt_rd;
          end else if (is_l) begin
            last_nxt[oi] = prv_rd;
          end else begin
            nxt_we = 1'b1;
            nxt_wa = prv_rd;
            nxt_wd = nxt_rd;
            prv_we = 1'b1;
            prv_wa = nxt_rd;
            prv_wd = prv_rd;
          end
          state_nxt = S_FMRG3;
        end
      end
      S_FMRG3: begin
        nxt_we    = 1'b1;
        nxt_wa    = b_r;
        prv_we    = 1'b1;
        prv_wa    = b_r;
        ord_we    = 1'b1;
        ord_wa    = hi;
        ord_wd    = NOT_HEAD;
        state_nxt = S_FMRG4;
      end
      S_FMRG4: begin
        ord_we    = 1'b1;
        ord_wa    = lo;
        ord_wd    = ORD_W'(op1);
        p_nxt     = lo;
        o_nxt     = op1;
        state_nxt = S_FMRG;
      end
      S_FPUSH: begin
        nxt_we = 1'b1;
        if (ne_r[oi]) begin
          prv_we = 1'b1;
          prv_wa = first_r[oi];
          prv_wd = p_r;
          nxt_wd = first_r[oi];
        end else begin
          last_nxt[oi] = p_r;
          ne_nxt[oi]   = 1'b1;
        end
        first_nxt[oi] = p_r;
        state_nxt     = S_FPUSH2;
      end
      S_FPUSH2: begin
        prv_we     = 1'b1;
        fin        = 1'b1;
        fin_status = ST_OK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    page_nxt      = page_r;
    addr_nxt      = addr_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
      status_nxt    = fin_status;
      if (fin_status == ST_OK) begin
        page_nxt = PAGE_W'(p_r);
        addr_nxt = base_r + (ADDR_W'(p_r) << PG_BYTE_LOG2);
      end else begin
        page_nxt = '0;
        addr_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < ORDER_LEVELS; k++) begin
        first_r[k] <= '0;
        last_r[k]  <= '0;
        ne_r[k]    <= 1'b0;
      end
      if (FULL > 0) begin
        ne_r[TOP]   <= 1'b1;
        last_r[TOP] <= PW'(LAST_TOP);
      end
      if (FULL < NUM_PAGES) begin
        ne_r[0]    <= 1'b1;
        first_r[0] <= PW'(FULL);
        last_r[0]  <= PW'(NUM_PAGES - 1);
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      ne_r        <= ne_nxt;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_pool_base_address;
      end
    end
  end

  always_ff @(posedge clk) begin
    o_r      <= o_nxt;
    req_r    <= req_nxt;
    pidx_r   <= pidx_nxt;
    p_r      <= p_nxt;
    b_r      <= b_nxt;
    status_r <= status_nxt;
    page_r   <= page_nxt;
    addr_r   <= addr_nxt;
  end

endmodule

>>> sv/bpa_checker.sv
`include "buddy_page_allocator_assert.svh"

module bpa_checker
  import bpa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_mode,
  input logic [ORD_W-1:0]  in_block_order,
  input logic [PAGE_W-1:0] in_page_index,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] out_status,
  input logic [PAGE_W-1:0] out_result_page,
  input logic [ADDR_W-1:0] out_result_address,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [ADDR_W-1:0] cfg_pool_base_address
);

  // a result still waiting blocks new transactions
  `BPA_ASSERT_NOW(a_wait_blocks_in, out_valid, in_stall)

  // an accepted transaction keeps the input side stalled on the next cycle
  `BPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // failed requests carry a zero page and address
  `BPA_ASSERT_NOW(a_fail_zero, out_valid && out_status != ST_OK,
                  out_result_page == '0 && out_result_address == '0)

  // a stalled result is not dropped
  `BPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status))

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);

>>> dv/buddy_page_allocator_tb.sv
`timescale 1ns / 100ps

class alloc_scoreboard;
  localparam int NPG = 1024;
  localparam int TOPO = 8;

  bit [31:0] base_addr;
  bit        busy [NPG];
  bit [3:0]  head_ord [NPG];
  bit [9:0]  nxt [NPG];
  bit [9:0]  prv [NPG];
  bit [9:0]  first [TOPO+1];
  bit [9:0]  last [TOPO+1];
  bit        nonempty [TOPO+1];

  bit [1:0]  exp_status [$];
  bit [9:0]  exp_page [$];
  bit [31:0] exp_addr [$];
  int        errors;

  // pages handed out and not yet freed, for generating legal frees
  bit [9:0]  live_page [$];
  bit [3:0]  live_ord [$];

  function void push_tail(int o, bit [9:0] p);
    if (nonempty[o]) begin
      nxt[last[o]] = p;
      prv[p] = last[o];
    end else begin
      first[o] = p;
      prv[p] = 0;
      nonempty[o] = 1;
    end
    nxt[p] = 0;
    last[o] = p;
  endfunction

  function void push_head(int o, bit [9:0] p);
    if (nonempty[o]) begin
      prv[first[o]] = p;
      nxt[p] = first[o];
    end else begin
      last[o] = p;
      nxt[p] = 0;
      nonempty[o] = 1;
    end
    prv[p] = 0;
    first[o] = p;
  endfunction

  function void unlink(int o, bit [9:0] p);
    bit f, l;
    f = first[o] == p;
    l = last[o] == p;
    if (f && l) begin
      nonempty[o] = 0;
      first[o] = 0;
      last[o] = 0;
    end else if (f) begin
      first[o] = nxt[p];
    end else if (l) begin
      last[o] = prv[p];
    end else begin
      nxt[prv[p]] = nxt[p];
      prv[nxt[p]] = prv[p];
    end
    nxt[p] = 0;
    prv[p] = 0;
  endfunction

  function void reset_state();
    base_addr = 0;
    for (int o = 0; o <= TOPO; o++) begin
      first[o] = 0;
      last[o] = 0;
      nonempty[o] = 0;
    end
    for (int i = 0; i < NPG; i++) begin
      busy[i] = 0;
      nxt[i] = 0;
      prv[i] = 0;
      if (i % (1 << TOPO) == 0) begin
        head_ord[i] = 4'(TOPO);
        push_tail(TOPO, 10'(i));
      end else begin
        head_ord[i] = bpa_pkg::NOT_HEAD;
      end
    end
    live_page.delete();
    live_ord.delete();
    errors = 0;
  endfunction

  function void note_request(bit mode, bit [3:0] req, bit [9:0] pidx);
    bit [1:0] st;
    int p, o, sz, b;
    st = bpa_pkg::ST_OK;
    p = 0;
    if (req > TOPO) begin
      st = bpa_pkg::ST_BAD;
    end else if (mode == bpa_pkg::MODE_ALLOC) begin
      o = req;
      while (o <= TOPO && !nonempty[o]) o++;
      if (o > TOPO) begin
        st = bpa_pkg::ST_NOFREE;
      end else begin
        p = first[o];
        unlink(o, 10'(p));
        while (o > req) begin
          o--;
          head_ord[p] = 4'(o);
          push_tail(o, 10'(p));
          p += 1 << o;
        end
        busy[p] = 1;
        head_ord[p] = req;
        live_page.push_back(10'(p));
        live_ord.push_back(req);
      end
    end else begin
      sz = 1 << req;
      if ((pidx & (sz - 1)) != 0 || pidx + sz > NPG) begin
        st = bpa_pkg::ST_BAD;
      end else if (!busy[pidx] || head_ord[pidx] != req) begin
        st = bpa_pkg::ST_NOTALLOC;
      end else begin
        o = req;
        p = pidx;
        busy[p] = 0;
        for (int i = 0; i < live_page.size(); i++)
          if (live_page[i] == pidx) begin
            live_page.delete(i);
            live_ord.delete(i);
            break;
          end
        while (o < TOPO) begin
          b = p ^ (1 << o);
          if (b >= NPG || busy[b] || head_ord[b] != o) break;
          unlink(o, 10'(b));
          if (b < p) begin
            head_ord[p] = bpa_pkg::NOT_HEAD;
            p = b;
          end else begin
            head_ord[b] = bpa_pkg::NOT_HEAD;
          end
          o++;
          head_ord[p] = 4'(o);
        end
        push_head(o, 10'(p));
      end
    end
    exp_status.push_back(st);
    exp_page.push_back(st == bpa_pkg::ST_OK ? p[9:0] : 10'd0);
    exp_addr.push_back(st == bpa_pkg::ST_OK ? base_addr + (32'(p) << 12) : 32'd0);
  endfunction

  function void check_result(bit [1:0] st, bit [9:0] pg, bit [31:0] ad);
    bit [1:0] es;
    bit [9:0] ep;
    bit [31:0] ea;
    if (exp_status.size() == 0) begin
      $display("%0t: unexpected result status %0d page %0d", $time, st, pg);
      errors++;
      return;
    end
    es = exp_status.pop_front();
    ep = exp_page.pop_front();
    ea = exp_addr.pop_front();
    if (st !== es) begin
      $display("%0t: status expected %0d actual %0d", $time, es, st);
      errors++;
    end
    if (pg !== ep) begin
      $display("%0t: page expected %0d actual %0d", $time, ep, pg);
      errors++;
    end
    if (ad !== ea) begin
      $display("%0t: address expected %h actual %h", $time, ea, ad);
      errors++;
    end
  endfunction
endclass

module buddy_page_allocator_tb;
  import bpa_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_mode;
  logic [ORD_W-1:0]  in_block_order;
  logic [PAGE_W-1:0] in_page_index;
  logic              out_valid;
  logic              out_stall;
  logic [STAT_W-1:0] out_status;
  logic [PAGE_W-1:0] out_result_page;
  logic [ADDR_W-1:0] out_result_address;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_pool_base_address;

  alloc_scoreboard sb;
  bit fill_phase;

  buddy_page_allocator u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_block_order       (in_block_order),
    .in_page_index        (in_page_index),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_result_page      (out_result_page),
    .out_result_address   (out_result_address),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_pool_base_address(cfg_pool_base_address)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // valid stays up from one transaction into the next when there is no gap
  task automatic send_request(bit mode, bit [3:0] ord, bit [9:0] pidx);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1;
    in_mode        <= mode;
    in_block_order <= ord;
    in_page_index  <= pidx;
    do @(posedge clk); while (in_stall);
    sb.note_request(mode, ord, pidx);
  endtask

  task automatic write_base(bit [31:0] v);
    cfg_valid             <= 1;
    cfg_pool_base_address <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.base_addr = v;
    cfg_valid <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.exp_status.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // result side: random stall per transaction, with calm stretches
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_result_page, out_result_address);
  end

  initial begin
    int stall_left;
    out_stall <= 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        stall_left = fill_phase ? 0 : $urandom_range(0, 13);
      end
      if (stall_left > 0) begin
        out_stall <= 1;
        stall_left--;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic random_request();
    int r;
    bit [3:0] o;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      // mostly small orders, a few large
      o = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(0, 3));
      send_request(MODE_ALLOC, o, 10'($urandom));
    end else if (r < 88 && sb.live_page.size() > 0) begin
      int k;
      k = $urandom_range(0, sb.live_page.size() - 1);
      send_request(MODE_FREE, sb.live_ord[k], sb.live_page[k]);
    end else begin
      send_request(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 10'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    fill_phase = 0;
    rst_n = 0;
    in_valid = 0;
    in_mode = 0;
    in_block_order = 0;
    in_page_index = 0;
    cfg_valid = 0;
    cfg_pool_base_address = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed: bad orders, extremes, not-allocated, exhaustion and merge back
    write_base(32'h0000_0000);
    send_request(MODE_ALLOC, 4'd15, 10'h3FF);
    send_request(MODE_FREE, 4'd9, 10'd0);
    send_request(MODE_FREE, 4'd0, 10'd5);
    send_request(MODE_FREE, 4'd2, 10'd3);
    send_request(MODE_FREE, 4'd8, 10'd512);
    send_request(MODE_FREE, 4'd8, 10'd128);
    send_request(MODE_ALLOC, 4'd0, 10'd0);
    send_request(MODE_ALLOC, 4'd8, 10'h3FF);
    send_request(MODE_ALLOC, 4'd8, 10'd0);
    send_request(MODE_ALLOC, 4'd8, 10'd0);
    send_request(MODE_ALLOC, 4'd8, 10'd0);
    send_request(MODE_ALLOC, 4'd1, 10'd0);
    send_request(MODE_FREE, 4'd0, 10'd1023);
    send_request(MODE_FREE, 4'd0, 10'd1023);
    send_request(MODE_FREE, 4'd8, 10'd768);
    drain();
    write_base(32'hFFFF_F000);
    while (sb.live_page.size() > 0)
      send_request(MODE_FREE, sb.live_ord[0], sb.live_page[0]);
    drain();

    write_base(32'h1234_5000);
    repeat (300) random_request();
    drain();
    write_base(32'hFFFF_F000);
    repeat (300) random_request();
    drain();
    // exhaust the pool with order-0 pages to reach the no-free case
    fill_phase = 1;
    write_base($urandom & 32'hFFFF_F000);
    repeat (1030) send_request(MODE_ALLOC, 4'd0, 10'($urandom));
    fill_phase = 0;
    repeat (300) random_request();
    drain();

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
